// ----- hdl/sorted_integer_set_defines.svh -----
// Assertion macros for the sorted set block. All of them sample on clk and
// are disabled while rst_n is low.
`ifndef SORTED_INTEGER_SET_DEFINES_SVH
`define SORTED_INTEGER_SET_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SIS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SIS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/sis_pkg.sv -----
package sis_pkg;

  localparam int KEY_W  = 32;
  localparam int SIZE_W = 5;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_ERASE  = 2'd1;
  localparam logic [1:0] OP_LOOKUP = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [KEY_W-1:0] key_value;
  } in_item_t;

  typedef struct packed {
    logic              was_present;
    logic              accepted;
    logic [SIZE_W-1:0] set_size;
  } out_item_t;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic compare;
    logic insert;
    logic erase;
    logic clear;
  } cell_cmd_t;

endpackage

// ----- hdl/sis_cell.sv -----
module sis_cell #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  sis_pkg::cell_cmd_t     cmd,
  input  logic [VALUE_WIDTH-1:0] key,
  input  logic [VALUE_WIDTH-1:0] left_value,
  input  logic                   left_valid,
  input  logic                   left_mark,
  input  logic [VALUE_WIDTH-1:0] right_value,
  input  logic                   right_valid,
  output logic [VALUE_WIDTH-1:0] value_o,
  output logic                   valid_o,
  output logic                   mark_o,
  output logic                   eq_o
);

  logic [VALUE_WIDTH-1:0] value_r, value_nxt;
  logic                   valid_r, valid_nxt;
  logic                   mark_r, mark_nxt;
  logic                   eq_r, eq_nxt;

  // The mark flags the cells at or after the position of the key: an empty
  // cell, or one holding a value not below the key. Valid cells form a
  // prefix, so the marks form a suffix of the chain.
  always_comb begin
    value_nxt = value_r;
    valid_nxt = valid_r;
    mark_nxt  = mark_r;
    eq_nxt    = eq_r;
    if (cmd.compare) begin
      mark_nxt = !valid_r || (value_r >= key);
      eq_nxt   = valid_r && (value_r == key);
    end
    if (cmd.clear) begin
      valid_nxt = 1'b0;
    end else if (cmd.insert && mark_r) begin
      if (left_mark) begin
        value_nxt = left_value;
        valid_nxt = left_valid;
      end else begin
        value_nxt = key;
        valid_nxt = 1'b1;
      end
    end else if (cmd.erase && mark_r) begin
      value_nxt = right_value;
      valid_nxt = right_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      mark_r  <= 1'b0;
      eq_r    <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      mark_r  <= mark_nxt;
      eq_r    <= eq_nxt;
    end
    value_r <= value_nxt;
  end

  assign value_o = value_r;
  assign valid_o = valid_r;
  assign mark_o  = mark_r;
  assign eq_o    = eq_r;

endmodule

// ----- hdl/sorted_integer_set.sv -----
// Each request runs a compare cycle, in which every cell of the chain checks
// the key, then an update cycle that shifts cells; the result is registered
// at the end of the update cycle, and the next request is taken no earlier.
// A result waiting on out_stall holds the update cycle and the next request.
// Reset (synchronous, rst_n low) empties the set; stored values keep no reset.
module sorted_integer_set #(
  parameter int CAPACITY    = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  sis_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output sis_pkg::out_item_t  out_data
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CMP  = 2'd1;
  localparam logic [1:0] ST_UPD  = 2'd2;

  logic [1:0]             state_r, state_nxt;
  logic [1:0]             op_r, op_nxt;
  logic [VALUE_WIDTH-1:0] key_r, key_nxt;
  logic [CNT_W-1:0]       count_r, count_nxt;
  logic                   out_valid_r, out_valid_nxt;
  sis_pkg::out_item_t     out_data_r, out_data_nxt;

  logic [63:0]            key_ext;
  logic                   accept;
  logic                   upd_done;
  logic                   hit;
  logic                   full;
  logic                   present;
  logic                   ins_ok;
  logic [CNT_W+sis_pkg::SIZE_W-1:0] size_ext;
  sis_pkg::cell_cmd_t     cmd;

  logic [VALUE_WIDTH-1:0] cell_value [CAPACITY];
  logic [CAPACITY-1:0]    cell_valid;
  logic [CAPACITY-1:0]    cell_mark;
  logic [CAPACITY-1:0]    cell_eq;

  assign key_ext  = {32'd0, in_data.key_value};
  assign upd_done = (state_r == ST_UPD) && !(out_valid_r && out_stall);
  assign in_stall = !((state_r == ST_IDLE) || upd_done);
  assign accept   = in_valid && !in_stall;

  assign hit     = |cell_eq;
  assign full    = (count_r == CNT_W'(CAPACITY));
  assign present = hit && (op_r != sis_pkg::OP_CLEAR);
  assign ins_ok  = (op_r == sis_pkg::OP_INSERT) && !hit && !full;

  always_comb begin
    cmd         = '0;
    cmd.compare = (state_r == ST_CMP);
    if (upd_done) begin
      cmd.insert = ins_ok;
      cmd.erase  = (op_r == sis_pkg::OP_ERASE) && hit;
      cmd.clear  = (op_r == sis_pkg::OP_CLEAR);
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.clear) begin
      count_nxt = '0;
    end else if (cmd.insert) begin
      count_nxt = count_r + 1'b1;
    end else if (cmd.erase) begin
      count_nxt = count_r - 1'b1;
    end
  end

  assign size_ext = {{sis_pkg::SIZE_W{1'b0}}, count_nxt};

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    key_nxt       = key_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_CMP;
        end
      end
      ST_CMP: begin
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        if (upd_done) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.was_present = present;
          out_data_nxt.accepted    = !((op_r == sis_pkg::OP_INSERT) && !hit && full);
          out_data_nxt.set_size    = size_ext[sis_pkg::SIZE_W-1:0];
          state_nxt                = accept ? ST_CMP : ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    if (accept) begin
      op_nxt  = in_data.req_type;
      key_nxt = key_ext[VALUE_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r       <= op_nxt;
    key_r      <= key_nxt;
    out_data_r <= out_data_nxt;
  end

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      logic [VALUE_WIDTH-1:0] lv, rv;
      logic                   lvld, lmark, rvld;
      if (gi == 0) begin : g_first
        assign lv    = '0;
        assign lvld  = 1'b0;
        assign lmark = 1'b0;
      end else begin : g_mid
        assign lv    = cell_value[gi-1];
        assign lvld  = cell_valid[gi-1];
        assign lmark = cell_mark[gi-1];
      end
      if (gi == CAPACITY - 1) begin : g_last
        assign rv   = '0;
        assign rvld = 1'b0;
      end else begin : g_inner
        assign rv   = cell_value[gi+1];
        assign rvld = cell_valid[gi+1];
      end
      sis_cell #(
        .VALUE_WIDTH(VALUE_WIDTH)
      ) u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .key        (key_r),
        .left_value (lv),
        .left_valid (lvld),
        .left_mark  (lmark),
        .right_value(rv),
        .right_valid(rvld),
        .value_o    (cell_value[gi]),
        .valid_o    (cell_valid[gi]),
        .mark_o     (cell_mark[gi]),
        .eq_o       (cell_eq[gi])
      );
    end
  endgenerate

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- hdl/sis_checker.sv -----
`include "sorted_integer_set_defines.svh"

module sis_checker #(
  parameter int CAPACITY = 16
) (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input sis_pkg::out_item_t out_data
);

  localparam logic [sis_pkg::SIZE_W-1:0] CAP_SIZE = sis_pkg::SIZE_W'(CAPACITY);

  // A stalled result transaction keeps its payload.
  `SIS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "result changed while stalled")

  // The block compares before it updates, so it never takes two in a row.
  `SIS_ASSERT_NEXT(a_two_cycle, in_valid && !in_stall, in_stall, "request taken in the compare cycle")

  // A rejected insert only happens when the set is full.
  `SIS_ASSERT_NOW(a_reject_full, out_valid && !out_data.accepted, (out_data.set_size == CAP_SIZE) && !out_data.was_present, "insert rejected below capacity")

  // When the capacity is below 32, the reported size never exceeds it.
  `SIS_ASSERT_NOW(a_size_cap, out_valid && (CAPACITY < 32), out_data.set_size <= CAP_SIZE, "set size above capacity")

endmodule

bind sorted_integer_set sis_checker #(.CAPACITY(CAPACITY)) u_sis_checker (.*);
